[design/battery_level_tracker_top_assert.svh]
// Assertion macros used by the battery level tracker top level
`ifndef BATTERY_LEVEL_TRACKER_TOP_ASSERT_SVH
`define BATTERY_LEVEL_TRACKER_TOP_ASSERT_SVH

// same-cycle implication, checked on clk, quiet while arst_n is low
`define BLT_ASSERT_NOW(label, ante, cons) \
	label: assert property (@(posedge clk) disable iff (!arst_n) (ante) |-> (cons)) \
		else $error("battery level tracker check failed");

// next-cycle implication, checked on clk, quiet while arst_n is low
`define BLT_ASSERT_NEXT(label, ante, cons) \
	label: assert property (@(posedge clk) disable iff (!arst_n) (ante) |=> (cons)) \
		else $error("battery level tracker check failed");

`endif

[design/blt_pkg.sv]
// Shared types and constants for the battery level tracker
package blt_pkg;

	localparam int unsigned SampleW = 10;
	localparam int unsigned LevelW  = 7;

	localparam logic [LevelW-1:0] LevelMax      = 7'd100;
	localparam logic [LevelW-1:0] ThresholdRst  = 7'd4;

	// piecewise mapping breakpoints
	localparam logic [SampleW-1:0] LinearLo     = 10'd528;
	localparam logic [SampleW-1:0] LinearOffset = 10'd478;
	localparam logic [SampleW-1:0] LinearSat    = 10'd578;
	localparam logic [SampleW-1:0] MidLo        = 10'd512;
	localparam logic [SampleW-1:0] KneeLo       = 10'd480;

	// input beat
	typedef struct packed {
		logic [SampleW-1:0] adc_sample;
		logic               charging;
	} blt_in_t;

	// result beat
	typedef struct packed {
		logic [LevelW-1:0] level;
		logic              charger_on;
		logic              low_battery;
	} blt_out_t;

endpackage

[design/blt_map.sv]
// Piecewise map from a converter sample to a target percentage, clamped to 0..100
module blt_map import blt_pkg::*; (
	input  logic [SampleW-1:0] adc_sample,
	output logic [LevelW-1:0]  target
);

	logic [SampleW-1:0] lin_d;
	logic [3:0]         mid_k;
	logic [7:0]         mid_p;
	logic [4:0]         knee_k;
	logic [19:0]        knee_p;
	logic [4:0]         knee_q;

	// upper linear piece: s - 478, saturating at 100 from s = 578 up
	assign lin_d = adc_sample - LinearOffset;

	// middle piece: (17*s >> 3) - 1068 with s = 512 + k reduces to 20 + (17*k >> 3)
	assign mid_k = adc_sample[3:0];
	assign mid_p = 8'(mid_k) * 8'd17;

	// knee piece: 16*k/31 as a reciprocal multiply, 16*1058 = 16928, exact for k < 32
	assign knee_k = adc_sample[4:0];
	assign knee_p = 20'(knee_k) * 20'd16928;
	assign knee_q = knee_p[19:15];

	// select the piece
	always_comb begin
		priority if (adc_sample >= LinearSat) begin
			target = LevelMax;
		end else if (adc_sample >= LinearLo) begin
			target = lin_d[LevelW-1:0];
		end else if (adc_sample >= MidLo) begin
			target = 7'd20 + 7'(mid_p[7:3]);
		end else if (adc_sample >= KneeLo) begin
			target = 7'd4 + 7'(knee_q);
		end else begin
			target = '0;
		end
	end

endmodule

[design/blt_track.sv]
// Tracked level state: snap or one-step update and low battery compare
module blt_track import blt_pkg::*; (
	input  logic              clk,
	input  logic              arst_n,
	input  logic              update,
	input  logic              charging,
	input  logic [LevelW-1:0] target,
	input  logic [LevelW-1:0] low_threshold,
	output logic [LevelW-1:0] level,
	output logic              low_battery
);

	logic [LevelW-1:0] tracked_q;
	logic              first_q;
	logic              was_chg_q;

	// next level: hold while charging, snap after reset or charge end, else step
	always_comb begin
		priority if (charging) begin
			level = tracked_q;
		end else if (first_q || was_chg_q) begin
			level = target;
		end else if (tracked_q > target) begin
			level = tracked_q - 7'd1;
		end else if (tracked_q < target) begin
			level = tracked_q + 7'd1;
		end else begin
			level = tracked_q;
		end
	end

	assign low_battery = !charging && (level <= low_threshold);

	// state registers, advanced once per beat
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			tracked_q <= '0;
			first_q   <= 1'b1;
			was_chg_q <= 1'b0;
		end else if (update) begin
			tracked_q <= level;
			first_q   <= 1'b0;
			was_chg_q <= charging;
		end
	end

endmodule

[design/battery_level_tracker_top.sv]
// Battery level tracker top level: input register, mapping, tracking, result register
// Each sample beat (10-bit converter reading plus charging flag) yields one result
// beat, registered in the input register and then in the result register; a new
// sample is taken every cycle, one per clock, unless an untaken result (result_ready
// low) stalls the input register. The sample is mapped to a target percentage, the
// level snaps to it on the first sample after reset or after charging ends and
// otherwise steps by one toward it, and is held while charging. low_battery is set
// when not charging and the level is at or below low_threshold (reset 4), which the
// user must write via cfg_we/cfg_wdata only while idle; the block does not enforce it.
`include "battery_level_tracker_top_assert.svh"

module battery_level_tracker_top import blt_pkg::*; (
	input  logic              clk,
	input  logic              arst_n,
	input  logic              sample_valid,
	output logic              sample_ready,
	input  blt_in_t           sample,
	output logic              result_valid,
	input  logic              result_ready,
	output blt_out_t          result,
	input  logic              cfg_we,
	input  logic [LevelW-1:0] cfg_wdata
);

	blt_in_t           sample_s1;
	logic              valid_s1;
	blt_out_t          result_q;
	logic              result_valid_q;
	logic [LevelW-1:0] low_threshold_q;
	logic              advance;
	logic [LevelW-1:0] target;
	logic [LevelW-1:0] level_nxt;
	logic              low_nxt;

	// stage handshake
	assign advance      = valid_s1 && (!result_valid_q || result_ready);
	assign sample_ready = !valid_s1 || advance;

	// threshold register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			low_threshold_q <= ThresholdRst;
		end else if (cfg_we) begin
			low_threshold_q <= cfg_wdata;
		end
	end

	// input register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (sample_ready) begin
			valid_s1 <= sample_valid;
		end
	end

	always_ff @(posedge clk) begin
		if (sample_valid && sample_ready) begin
			sample_s1 <= sample;
		end
	end

	blt_map u_map (
		.adc_sample (sample_s1.adc_sample),
		.target     (target)
	);

	blt_track u_track (
		.clk           (clk),
		.arst_n        (arst_n),
		.update        (advance),
		.charging      (sample_s1.charging),
		.target        (target),
		.low_threshold (low_threshold_q),
		.level         (level_nxt),
		.low_battery   (low_nxt)
	);

	// result register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			result_valid_q <= 1'b0;
		end else if (advance) begin
			result_valid_q <= 1'b1;
		end else if (result_ready) begin
			result_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (advance) begin
			result_q.level       <= level_nxt;
			result_q.charger_on  <= sample_s1.charging;
			result_q.low_battery <= low_nxt;
		end
	end

	assign result_valid = result_valid_q;
	assign result       = result_q;

	// checks
	`BLT_ASSERT_NOW(a_low_not_charging, result_valid && result.low_battery, !result.charger_on)
	`BLT_ASSERT_NOW(a_level_range, result_valid, result.level <= LevelMax)
	`BLT_ASSERT_NOW(a_stall_cause, !sample_ready, result_valid && !result_ready)
	`BLT_ASSERT_NEXT(a_result_follows, advance, result_valid)

endmodule
